// ===== rtl/lir_pkg.sv =====
`default_nettype none

package lir_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int REG_W       = 24;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int COUNT_BITS  = 24;
  localparam int FRAC_BITS   = 16;
  localparam int PHASE_W     = COUNT_BITS + FRAC_BITS;
  localparam int MAX_RESULTS = 16;
  localparam int N_W         = $clog2(MAX_RESULTS + 1);
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int PROD_W      = DIFF_W + FRAC_BITS + 1;
  localparam int NUM_W       = PROD_W + 1;
  localparam int Q_W         = NUM_W - FRAC_BITS;
  localparam int LIM_W       = ((PHASE_W > REG_W + FRAC_BITS) ? PHASE_W : REG_W + FRAC_BITS) + 1;
  localparam int FIN_W       = ((COUNT_BITS > REG_W) ? COUNT_BITS : REG_W) + 1;

  localparam logic [REG_W-1:0] RATIO_RESET = REG_W'(65536);

  localparam logic REG_RATIO = 1'b0;
  localparam logic REG_TOTAL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MULT,
    ST_BLEND
  } state_t;

  typedef struct packed {
    logic start;
    logic emit;
    logic mult;
    logic blend;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic have_hold;
    logic out_free;
    logic total_zero;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/lir_ctrl.sv =====
`default_nettype none

module lir_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  lir_pkg::status_t status,
  output lir_pkg::cmd_t    cmd
);
  import lir_pkg::*;

  state_t state;
  state_t state_next;

  logic check_go;

  assign check_go = !status.have_hold || status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !status.total_zero) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (check_go) state_next = status.ok ? ST_MULT : ST_IDLE;
      end
      ST_MULT:  state_next = ST_BLEND;
      ST_BLEND: state_next = ST_CHECK;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_CHECK: begin
        cmd.emit   = status.have_hold && status.out_free;
        cmd.finish = check_go && !status.ok;
      end
      ST_MULT:  cmd.mult  = 1'b1;
      ST_BLEND: cmd.blend = 1'b1;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lir_dpath.sv =====
`default_nettype none

module lir_dpath (
  input  wire                           clk,
  input  wire                           rst,
  input  wire  [lir_pkg::REG_W-1:0]     resample_ratio,
  input  wire  [lir_pkg::REG_W-1:0]     total_samples,
  input  wire  [lir_pkg::SAMPLE_W-1:0]  in_sample,
  input  lir_pkg::cmd_t                 cmd,
  output lir_pkg::status_t              status,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [lir_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                          run_last,
  output logic                          stream_end
);
  import lir_pkg::*;

  localparam logic [NUM_W-1:0] TRUNC_ADJ = NUM_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(32767);
  localparam logic signed [Q_W-1:0] SAT_LO = Q_W'(-32768);

  logic [SAMPLE_W-1:0]      prev;
  logic [COUNT_BITS-1:0]    count;
  logic [PHASE_W-1:0]       phase;
  logic [SAMPLE_W-1:0]      cur;
  logic signed [DIFF_W-1:0] diff;
  logic [COUNT_BITS-1:0]    k;
  logic                     final_in;
  logic                     mode_interp;
  logic [N_W-1:0]           n;
  logic [SAMPLE_W-1:0]      hold;
  logic                     have_hold;
  logic                     interp_q;
  logic signed [PROD_W-1:0] prod;

  logic                     due;
  logic                     interp;
  logic                     ok;
  logic signed [FRAC_BITS:0] frac_s;
  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         adj;
  logic signed [Q_W-1:0]    quot;
  logic [SAMPLE_W-1:0]      blended;

  assign due = (LIM_W'(phase) + LIM_W'(resample_ratio >> 1))
               <= LIM_W'({total_samples, {FRAC_BITS{1'b0}}});
  assign interp = mode_interp && (k != '0) && (phase[PHASE_W-1:FRAC_BITS] < k);
  assign ok = (n < N_W'(MAX_RESULTS)) && due && (interp || final_in);

  assign frac_s = {1'b0, phase[FRAC_BITS-1:0]};

  // truncate toward zero, then saturate
  assign num = {{(NUM_W-SAMPLE_W-FRAC_BITS){prev[SAMPLE_W-1]}}, prev, {FRAC_BITS{1'b0}}}
               + {prod[PROD_W-1], prod};
  assign adj = num + (num[NUM_W-1] ? TRUNC_ADJ : '0);
  assign quot = adj[NUM_W-1:FRAC_BITS];

  always_comb begin
    if (quot > SAT_HI) begin
      blended = SAMPLE_W'(SAT_HI);
    end else if (quot < SAT_LO) begin
      blended = SAMPLE_W'(SAT_LO);
    end else begin
      blended = quot[SAMPLE_W-1:0];
    end
  end

  assign status.ok         = ok;
  assign status.have_hold  = have_hold;
  assign status.out_free   = !out_valid || out_ready;
  assign status.total_zero = (total_samples == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      count     <= '0;
      phase     <= '0;
      have_hold <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        if (total_samples == '0) begin
          prev  <= '0;
          count <= '0;
          phase <= '0;
        end else begin
          have_hold <= 1'b0;
        end
      end
      if (cmd.blend) begin
        have_hold <= 1'b1;
        phase     <= phase + PHASE_W'(resample_ratio);
      end
      if (cmd.finish) begin
        if (final_in) begin
          prev  <= '0;
          count <= '0;
          phase <= '0;
        end else begin
          prev  <= cur;
          count <= k + COUNT_BITS'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur         <= in_sample;
      diff        <= {in_sample[SAMPLE_W-1], in_sample} - {prev[SAMPLE_W-1], prev};
      k           <= count;
      final_in    <= (FIN_W'(count) + FIN_W'(1)) >= FIN_W'(total_samples);
      mode_interp <= 1'b1;
      n           <= '0;
    end
    if (cmd.mult) begin
      interp_q <= interp;
      prod     <= diff * frac_s;
    end
    if (cmd.blend) begin
      hold <= interp_q ? blended : cur;
      n    <= n + N_W'(1);
      if (!interp_q) mode_interp <= 1'b0;
    end
    if (cmd.emit) begin
      out_sample <= hold;
      run_last   <= !ok;
      stream_end <= !ok && final_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/linear_interp_resampler.sv =====
// Linear interpolation resampler.
// Input stream (s_axis_*): one 16-bit signed sample per transaction. Each
// accepted sample releases every output whose read position falls between the
// held previous sample and this one; the final sample of a job also releases
// the remaining outputs at that sample's value. At most 16 outputs per input.
// Output stream (m_axis_*): interpolated sample in tdata, tlast on the last
// output caused by an input, tuser on the last output of the whole job.
// Config (APB): 0x0 resample_ratio (8.16), 0x4 total_samples. Write only
// between jobs or while the block is idle.
// Sequencing: each output passes through a check, a multiply and a blend
// step of the shared datapath, and is released one check later so that
// tlast is known.
// s_axis_tready is high only between inputs; the output register lets the
// next input be taken while the last output still waits. A stalled receiver
// holds the datapath in its check step until the output register frees up.
// Reset: job state cleared, ratio 1.0, total_samples 0, output stream empty.
`default_nettype none

module linear_interp_resampler (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [15:0]                        s_axis_tdata,   // [15:0] in_sample
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [15:0]                        m_axis_tdata,   // [15:0] out_sample
  output logic                               m_axis_tlast,
  output logic [0:0]                         m_axis_tuser,   // [0] stream_end
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [lir_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire  [lir_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lir_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import lir_pkg::*;

  logic [REG_W-1:0] resample_ratio;
  logic [REG_W-1:0] total_samples;
  logic             reg_sel;
  logic             cfg_wr;
  cmd_t             cmd;
  status_t          status;
  logic             stream_end;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      resample_ratio <= RATIO_RESET;
      total_samples  <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_RATIO: resample_ratio <= pwdata[REG_W-1:0];
        REG_TOTAL: total_samples  <= pwdata[REG_W-1:0];
        default:   resample_ratio <= resample_ratio;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_RATIO: prdata = APB_DATA_W'(resample_ratio);
      REG_TOTAL: prdata = APB_DATA_W'(total_samples);
      default:   prdata = '0;
    endcase
  end

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lir_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .resample_ratio (resample_ratio),
    .total_samples  (total_samples),
    .in_sample      (s_axis_tdata),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_sample     (m_axis_tdata),
    .run_last       (m_axis_tlast),
    .stream_end     (stream_end)
  );

  assign m_axis_tuser = stream_end;

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("stream_end without run_last");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (total_samples != '0) |=> !s_axis_tready)
    else $error("input taken while a transaction is in work");

  a_no_emit_when_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !cmd.emit && !cmd.blend)
    else $error("datapath active while idle");

endmodule

`default_nettype wire

// ===== tb/linear_interp_resampler_test.sv =====
`default_nettype none

module linear_interp_resampler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lir_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_ITEMS = 350;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
    logic                       fin;
  } resamp_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // [15:0] in_sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;        // [15:0] out_sample
  logic                  m_axis_tlast;
  logic [0:0]            m_axis_tuser;        // [0] stream_end
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  linear_interp_resampler dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state and register copies
  logic [REG_W-1:0]           ratio_cfg = RATIO_RESET;
  logic [REG_W-1:0]           total_cfg = '0;
  logic signed [SAMPLE_W-1:0] held_smp = '0;
  logic [COUNT_BITS-1:0]      in_cnt = '0;
  logic [PHASE_W-1:0]         rd_phase = '0;

  logic [15:0]  pending_samples[$];
  resamp_out_t  expected_outs[$];
  resamp_out_t  got_exp;

  int  errors = 0;
  int  cycles = 0;
  int  tx_idle = 11;
  int  rx_idle = 61;
  bit  in_fire = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  function automatic bit position_due();
    return (64'(rd_phase) + 64'(ratio_cfg >> 1)) <= (64'(total_cfg) << FRAC_BITS);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] lerp(input logic signed [SAMPLE_W-1:0] a,
                                                      input logic signed [SAMPLE_W-1:0] b,
                                                      input logic [FRAC_BITS-1:0] f);
    longint num;
    longint v;
    num = longint'(a) * (longint'(1) << FRAC_BITS) + (longint'(b) - longint'(a)) * longint'(f);
    v = num / (longint'(1) << FRAC_BITS);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic resample_step(input logic signed [SAMPLE_W-1:0] cur);
    int          n;
    bit          last_in;
    resamp_out_t r;
    n = 0;
    if (total_cfg == 0) begin
      held_smp = '0;
      in_cnt = '0;
      rd_phase = '0;
    end else begin
      last_in = ((25'(in_cnt) + 25'd1) >= 25'(total_cfg));
      r.last = 1'b0;
      r.fin = 1'b0;
      if (in_cnt != 0) begin
        while (n < MAX_RESULTS && rd_phase[PHASE_W-1:FRAC_BITS] < in_cnt && position_due()) begin
          r.smp = lerp(held_smp, cur, rd_phase[FRAC_BITS-1:0]);
          expected_outs.push_back(r);
          n++;
          rd_phase = rd_phase + PHASE_W'(ratio_cfg);
        end
      end
      if (last_in) begin
        while (n < MAX_RESULTS && position_due()) begin
          r.smp = cur;
          expected_outs.push_back(r);
          n++;
          rd_phase = rd_phase + PHASE_W'(ratio_cfg);
        end
        held_smp = '0;
        in_cnt = '0;
        rd_phase = '0;
      end else begin
        held_smp = cur;
        in_cnt = in_cnt + 1'b1;
      end
      if (n > 0) begin
        r = expected_outs.pop_back();
        r.last = 1'b1;
        r.fin = last_in;
        expected_outs.push_back(r);
      end
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (pending_samples.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_samples[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output receiver
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outs.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, got sample %0d last %0b end %0b",
                   $time, $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser[0]);
        end else begin
          got_exp = expected_outs.pop_front();
          if (m_axis_tdata !== got_exp.smp) begin
            errors++;
            $display("%0t: out_sample expected %0d got %0d",
                     $time, got_exp.smp, $signed(m_axis_tdata));
          end
          if (m_axis_tlast !== got_exp.last) begin
            errors++;
            $display("%0t: run_last expected %0b got %0b", $time, got_exp.last, m_axis_tlast);
          end
          if (m_axis_tuser[0] !== got_exp.fin) begin
            errors++;
            $display("%0t: stream_end expected %0b got %0b", $time, got_exp.fin, m_axis_tuser[0]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_samples.delete(0);
        resample_step(s_axis_tdata);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic apb_write(input logic idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= APB_DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_RATIO) ratio_cfg = val;
    else total_cfg = val;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || expected_outs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int               sent;
    int               n_items;
    int               guard;
    logic [REG_W-1:0] r;
    logic [REG_W-1:0] t;
    sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty job right after reset
    pending_samples.push_back(16'h7fff);
    pending_samples.push_back(16'h8000);
    wait_idle();

    // unit ratio, full-scale swings
    apb_write(REG_TOTAL, 24'd4);
    pending_samples.push_back(16'h7fff);
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(16'h0000);
    pending_samples.push_back(16'hffff);
    wait_idle();

    // smallest ratio: cap reached, held outputs dropped on the final input
    apb_write(REG_RATIO, 24'd4096);
    apb_write(REG_TOTAL, 24'd3);
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(16'h7fff);
    pending_samples.push_back(16'h8001);
    wait_idle();

    // half-step fractions, truncation toward zero
    apb_write(REG_RATIO, 24'd98304);
    apb_write(REG_TOTAL, 24'd5);
    pending_samples.push_back(-16'sd100);
    pending_samples.push_back(16'sd7);
    pending_samples.push_back(-16'sd3);
    pending_samples.push_back(16'sd1000);
    pending_samples.push_back(-16'sd1);
    wait_idle();

    // largest ratio: final input yields nothing
    apb_write(REG_RATIO, 24'hffffff);
    apb_write(REG_TOTAL, 24'd2);
    pending_samples.push_back(16'h1234);
    pending_samples.push_back(16'hedcb);
    wait_idle();

    // job length lowered partway through
    apb_write(REG_RATIO, 24'd40000);
    apb_write(REG_TOTAL, 24'd12);
    repeat (3) pending_samples.push_back(rand_sample());
    wait_idle();
    apb_write(REG_TOTAL, 24'd2);
    pending_samples.push_back(rand_sample());
    wait_idle();

    while (sent < RANDOM_ITEMS) begin
      if (sent >= 2 * RANDOM_ITEMS / 3) begin
        tx_idle = 0;
        rx_idle = 0;
      end else if (sent >= RANDOM_ITEMS / 3) begin
        tx_idle = 61;
        rx_idle = 11;
      end

      if (tx_idle == 0 && !hold_req) begin
        // long receiver stall with a dense job behind it
        r = 24'd4096;
        t = 24'd20;
        n_items = 20;
        hold_req = 1'b1;
      end else begin
        case ($urandom_range(0, 7))
          0: r = 24'd4096;
          1: r = 24'($urandom_range(24'h010000, 24'h200000));
          2: r = 24'd65536;
          default: r = 24'($urandom_range(4096, 24'h030000));
        endcase
        case ($urandom_range(0, 9))
          0: t = 24'd0;
          1: t = 24'hffffff;
          2: t = 24'd1;
          default: t = 24'($urandom_range(2, 24));
        endcase
        if (t == 0) n_items = 3;
        else if (t == 24'hffffff) n_items = $urandom_range(1, 20);
        else begin
          case ($urandom_range(0, 5))
            0: n_items = int'(t) - 1;
            1: n_items = int'(t) + 2;
            default: n_items = int'(t);
          endcase
        end
      end

      apb_write(REG_RATIO, r);
      apb_write(REG_TOTAL, t);
      for (int i = 0; i < n_items; i++) pending_samples.push_back(rand_sample());
      sent += n_items;
      wait_idle();
    end

    while (pending_samples.size() != 0) @(posedge clk);
    guard = 0;
    while (expected_outs.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_outs.size() != 0) begin
      errors++;
      $display("%0t: %0d expected transactions never arrived", $time, expected_outs.size());
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/lir_pkg.sv
rtl/lir_ctrl.sv
rtl/lir_dpath.sv
rtl/linear_interp_resampler.sv
tb/linear_interp_resampler_test.sv
